// ===== sv/prx_pkg.sv =====
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types, widths and the quarter-wave sine table for point_rotate_xyz.
// ----------------------------------------------------------------------------
package prx_pkg;

    localparam int ANGLE_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int COORD_BITS     = 16;

    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W      = ANGLE_BITS - 1;
    localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
    localparam int VAL_W      = 32;
    localparam int HS_W       = 16;
    localparam int COLOR_W    = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int LATENCY    = 11;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd3;

    localparam logic signed [HS_W-1:0] HS_RESET = 16'sd256;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic [COLOR_W-1:0]           point_color;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] rotated_x;
        logic signed [VAL_W-1:0] rotated_y;
        logic signed [VAL_W-1:0] rotated_z;
        logic [COLOR_W-1:0]      rotated_color;
    } out_t;

    typedef logic signed [TRIG_W-1:0] trig_tab_t [0:QUARTER];

    // Long division by shift and subtract; both operands are nonnegative.
    function automatic longint div_by_const(longint n, longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((n >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Sine over one quarter turn, built at elaboration from a Q28 Taylor series.
    function automatic trig_tab_t build_trig_table();
        trig_tab_t tab;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int i = 0; i <= QUARTER; i++)
        begin
            x = (longint'(i) * 64'sd421657428 + longint'(QUARTER >> 1)) >>> (ANGLE_BITS - 2);
            x2 = (x * x) >>> 28;
            term = x;
            sum = x;
            for (int k = 1; k <= 8; k++)
            begin
                term = (term * x2) >>> 28;
                term = div_by_const(term, longint'((2 * k) * (2 * k + 1)));
                if ((k & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 <<< 28))
                sum = 64'sd1 <<< 28;
            sum = (sum + (64'sd1 <<< (27 - TRIG_FRAC_BITS))) >>> (28 - TRIG_FRAC_BITS);
            tab[i] = TRIG_W'(sum);
        end
        return tab;
    endfunction

endpackage

// ===== sv/prx_trig.sv =====
// ----------------------------------------------------------------------------
// prx_trig
// Sine and cosine of one configured angle from the quarter-wave table.
// ----------------------------------------------------------------------------
module prx_trig (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [prx_pkg::ANGLE_BITS-1:0]       angle,
    output logic signed [prx_pkg::TRIG_W-1:0]    sin_val,
    output logic signed [prx_pkg::TRIG_W-1:0]    cos_val
);
    import prx_pkg::*;

    localparam trig_tab_t SINE_TAB = build_trig_table();

    logic [ANGLE_BITS-1:0]     cos_angle;
    logic [IDX_W-1:0]          sin_idx;
    logic [IDX_W-1:0]          cos_idx;
    logic signed [TRIG_W-1:0]  sin_tab_reg;
    logic signed [TRIG_W-1:0]  cos_tab_reg;
    logic                      sin_neg_reg;
    logic                      cos_neg_reg;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [TRIG_W-1:0]  cos_reg;

    assign cos_angle = angle + ANGLE_BITS'(QUARTER);

    // Odd quadrants read the table mirrored.
    always_comb
    begin
        sin_idx = {1'b0, angle[ANGLE_BITS-3:0]};
        if (angle[ANGLE_BITS-2])
            sin_idx = IDX_W'(QUARTER) - {1'b0, angle[ANGLE_BITS-3:0]};
        cos_idx = {1'b0, cos_angle[ANGLE_BITS-3:0]};
        if (cos_angle[ANGLE_BITS-2])
            cos_idx = IDX_W'(QUARTER) - {1'b0, cos_angle[ANGLE_BITS-3:0]};
    end

    always_ff @(posedge clk)
    begin
        sin_tab_reg <= SINE_TAB[sin_idx];
        cos_tab_reg <= SINE_TAB[cos_idx];
        sin_neg_reg <= angle[ANGLE_BITS-1];
        cos_neg_reg <= cos_angle[ANGLE_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg <= '0;
            cos_reg <= TRIG_W'(1 << TRIG_FRAC_BITS);
        end
        else
        begin
            sin_reg <= sin_neg_reg ? -sin_tab_reg : sin_tab_reg;
            cos_reg <= cos_neg_reg ? -cos_tab_reg : cos_tab_reg;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== sv/prx_scale.sv =====
// ----------------------------------------------------------------------------
// prx_scale
// Two-stage altitude scaling of a Q.8 height: multiply, then round and clamp.
// ----------------------------------------------------------------------------
module prx_scale (
    input  logic                               clk,
    input  logic signed [prx_pkg::VAL_W-1:0]   z,
    input  logic signed [prx_pkg::HS_W-1:0]    scale,
    output logic signed [prx_pkg::VAL_W-1:0]   zs
);
    import prx_pkg::*;

    localparam int PROD_W = VAL_W + HS_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  rounded;
    logic signed [VAL_W-1:0]  zs_next;
    logic signed [VAL_W-1:0]  zs_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(z) * PROD_W'(scale);
        zs_reg   <= zs_next;
    end

    always_comb
    begin
        rounded = (SUM_W'(prod_reg) + SUM_W'(128)) >>> 8;
        if (rounded > $signed({{(SUM_W-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}}))
            zs_next = {1'b0, {(VAL_W-1){1'b1}}};
        else if (rounded < $signed({{(SUM_W-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}}))
            zs_next = {1'b1, {(VAL_W-1){1'b0}}};
        else
            zs_next = rounded[VAL_W-1:0];
    end

    assign zs = zs_reg;

endmodule

// ===== sv/prx_rotate.sv =====
// ----------------------------------------------------------------------------
// prx_rotate
// Two-stage planar rotation: four products, then sums rounded and clamped.
// ----------------------------------------------------------------------------
module prx_rotate (
    input  logic                               clk,
    input  logic signed [prx_pkg::VAL_W-1:0]   a,
    input  logic signed [prx_pkg::VAL_W-1:0]   b,
    input  logic signed [prx_pkg::TRIG_W-1:0]  c,
    input  logic signed [prx_pkg::TRIG_W-1:0]  s,
    output logic signed [prx_pkg::VAL_W-1:0]   out_diff,
    output logic signed [prx_pkg::VAL_W-1:0]   out_sum
);
    import prx_pkg::*;

    localparam int PROD_W = VAL_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] ac_reg;
    logic signed [PROD_W-1:0] bs_reg;
    logic signed [PROD_W-1:0] as_reg;
    logic signed [PROD_W-1:0] bc_reg;
    logic signed [SUM_W-1:0]  diff_rnd;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [VAL_W-1:0]  diff_next;
    logic signed [VAL_W-1:0]  sum_next;
    logic signed [VAL_W-1:0]  diff_reg;
    logic signed [VAL_W-1:0]  sum_reg;

    localparam logic signed [SUM_W-1:0] MAX_V = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_V = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

    always_ff @(posedge clk)
    begin
        ac_reg   <= PROD_W'(a) * PROD_W'(c);
        bs_reg   <= PROD_W'(b) * PROD_W'(s);
        as_reg   <= PROD_W'(a) * PROD_W'(s);
        bc_reg   <= PROD_W'(b) * PROD_W'(c);
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
    end

    always_comb
    begin
        diff_rnd = (SUM_W'(ac_reg) - SUM_W'(bs_reg) + RND) >>> TRIG_FRAC_BITS;
        sum_rnd  = (SUM_W'(as_reg) + SUM_W'(bc_reg) + RND) >>> TRIG_FRAC_BITS;
        if (diff_rnd > MAX_V)
            diff_next = MAX_V[VAL_W-1:0];
        else if (diff_rnd < MIN_V)
            diff_next = MIN_V[VAL_W-1:0];
        else
            diff_next = diff_rnd[VAL_W-1:0];
        if (sum_rnd > MAX_V)
            sum_next = MAX_V[VAL_W-1:0];
        else if (sum_rnd < MIN_V)
            sum_next = MIN_V[VAL_W-1:0];
        else
            sum_next = sum_rnd[VAL_W-1:0];
    end

    assign out_diff = diff_reg;
    assign out_sum  = sum_reg;

endmodule

// ===== sv/point_rotate_xyz.sv =====
// ----------------------------------------------------------------------------
// point_rotate_xyz
// Rotates a map point about X, then Y, then Z, with altitude scaling of z.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, request           taken when start is high, busy low
//  result    done, result                   one cycle, marked by done
//  config    wr_en, wr_index, wr_data       written when wr_en is high
//
// One point enters every cycle; busy is always low. A result passes through an
// input register, then five registered units in series (scale, rotate, scale,
// rotate, rotate); the last scaling runs beside the last rotation.
// Reset clears the pipeline valid bits and the registers to their defaults.
// The receiver cannot stall, so nothing is held back inside.
module point_rotate_xyz (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  prx_pkg::in_t                      request,
    output logic                              done,
    output prx_pkg::out_t                     result,
    input  logic                              wr_en,
    input  logic [prx_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [prx_pkg::CFG_W-1:0]         wr_data
);
    import prx_pkg::*;

    logic [ANGLE_BITS-1:0]    angle_x_reg;
    logic [ANGLE_BITS-1:0]    angle_y_reg;
    logic [ANGLE_BITS-1:0]    angle_z_reg;
    logic signed [HS_W-1:0]   hs_reg;

    logic [LATENCY:1]         valid_reg;

    logic signed [TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

    logic signed [VAL_W-1:0]  x1_reg, y1_reg, z1_reg;
    logic signed [VAL_W-1:0]  x_pipe_reg [2:7];
    logic signed [VAL_W-1:0]  ya_pipe_reg [2:3];
    logic signed [VAL_W-1:0]  yb_pipe_reg [6:9];
    logic [COLOR_W-1:0]       col_pipe_reg [1:LATENCY];

    logic signed [VAL_W-1:0]  zs3, y5, z5, zs7, z9, x9, x11, y11, z11;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            hs_reg      <= HS_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ANGLE_X:      angle_x_reg <= wr_data[ANGLE_BITS-1:0];
                REG_ANGLE_Y:      angle_y_reg <= wr_data[ANGLE_BITS-1:0];
                REG_ANGLE_Z:      angle_z_reg <= wr_data[ANGLE_BITS-1:0];
                REG_HEIGHT_SCALE: hs_reg      <= $signed(wr_data[HS_W-1:0]);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LATENCY-1:1], start & ~busy};
    end

    // Coordinates enter as Q.8 values.
    always_ff @(posedge clk)
    begin
        x1_reg <= $signed({{(VAL_W-COORD_BITS-8){request.point_x[COORD_BITS-1]}},
                           request.point_x, 8'b0});
        y1_reg <= $signed({{(VAL_W-COORD_BITS-8){request.point_y[COORD_BITS-1]}},
                           request.point_y, 8'b0});
        z1_reg <= $signed({{(VAL_W-COORD_BITS-8){request.point_z[COORD_BITS-1]}},
                           request.point_z, 8'b0});
        col_pipe_reg[1] <= request.point_color;
        for (int i = 2; i <= LATENCY; i++)
            col_pipe_reg[i] <= col_pipe_reg[i-1];
        x_pipe_reg[2] <= x1_reg;
        for (int i = 3; i <= 7; i++)
            x_pipe_reg[i] <= x_pipe_reg[i-1];
        ya_pipe_reg[2] <= y1_reg;
        ya_pipe_reg[3] <= ya_pipe_reg[2];
        yb_pipe_reg[6] <= y5;
        for (int i = 7; i <= 9; i++)
            yb_pipe_reg[i] <= yb_pipe_reg[i-1];
    end

    prx_trig u_trig_x (.clk(clk), .rst_n(rst_n), .angle(angle_x_reg),
                       .sin_val(sin_x), .cos_val(cos_x));
    prx_trig u_trig_y (.clk(clk), .rst_n(rst_n), .angle(angle_y_reg),
                       .sin_val(sin_y), .cos_val(cos_y));
    prx_trig u_trig_z (.clk(clk), .rst_n(rst_n), .angle(angle_z_reg),
                       .sin_val(sin_z), .cos_val(cos_z));

    // About X: y' = y*c - zs*s, z' = y*s + zs*c.
    prx_scale  u_scale_x (.clk(clk), .z(z1_reg), .scale(hs_reg), .zs(zs3));
    prx_rotate u_rot_x (.clk(clk), .a(ya_pipe_reg[3]), .b(zs3), .c(cos_x), .s(sin_x),
                        .out_diff(y5), .out_sum(z5));

    // About Y: z' = zs*c - x*s, x' = zs*s + x*c.
    prx_scale  u_scale_y (.clk(clk), .z(z5), .scale(hs_reg), .zs(zs7));
    prx_rotate u_rot_y (.clk(clk), .a(zs7), .b(x_pipe_reg[7]), .c(cos_y), .s(sin_y),
                        .out_diff(z9), .out_sum(x9));

    // About Z: x' = x*c - y*s, y' = x*s + y*c, and z is scaled once more.
    prx_rotate u_rot_z (.clk(clk), .a(x9), .b(yb_pipe_reg[9]), .c(cos_z), .s(sin_z),
                        .out_diff(x11), .out_sum(y11));
    prx_scale  u_scale_z (.clk(clk), .z(z9), .scale(hs_reg), .zs(z11));

    assign done                 = valid_reg[LATENCY];
    assign result.rotated_x     = x11;
    assign result.rotated_y     = y11;
    assign result.rotated_z     = z11;
    assign result.rotated_color = col_pipe_reg[LATENCY];

endmodule

// ===== sv/point_rotate_xyz_checker.sv =====
// ----------------------------------------------------------------------------
// point_rotate_xyz_checker
// Port-level checks of request-to-result timing, colour and busy for point_rotate_xyz.
// ----------------------------------------------------------------------------
module point_rotate_xyz_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  prx_pkg::in_t   request,
    input  logic           done,
    input  prx_pkg::out_t  result
);
    import prx_pkg::*;

    // Every accepted request is followed by a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done)
        else $error("request without result");

    // No result appears without a request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 11))
        else $error("result without request");

    // The color travels with its point.
    a_color_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 (result.rotated_color == $past(request.point_color, 11)))
        else $error("color mismatch");

    // The block never refuses a request.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind point_rotate_xyz point_rotate_xyz_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
);

// ===== sim/point_rotate_xyz_test.sv =====
// ----------------------------------------------------------------------------
// point_rotate_xyz_test
// Self-checking bench for point_rotate_xyz: points are streamed through the
// block under several angle and altitude settings, and every result is
// checked against a fixed-point prediction of the three rotation stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_rotate_xyz_test;

    import prx_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_t                  request = '0;
    logic                 done;
    out_t                 result;
    logic                 wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0]     wr_data = '0;

    point_rotate_xyz DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data)
    );

    always #10 clk = ~clk;

    in_t     pending_points[$];
    out_t    rotated_expected[$];
    longint  sine_quarter[0:QUARTER];
    int      gap_left = 0;
    bit      calm = 1'b0;
    int      errors = 0;
    int      points_sent = 0;
    int      results_seen = 0;
    int      settings_used = 0;

    // Current register values as the block should hold them.
    logic [ANGLE_BITS-1:0] ang_x = '0, ang_y = '0, ang_z = '0;
    longint                alt_scale = 256;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest with ties toward plus infinity, then saturate.
    function automatic longint round_sat(longint v, int n);
        return clamp32((v + (64'sd1 <<< (n - 1))) >>> n);
    endfunction

    function automatic longint sine_at(logic [ANGLE_BITS-1:0] a);
        logic [1:0] quad;
        int         idx;
        longint     v;
        quad = a[ANGLE_BITS-1 -: 2];
        idx = int'(a[ANGLE_BITS-3:0]);
        if (quad[0])
            idx = QUARTER - idx;
        v = sine_quarter[idx];
        return quad[1] ? -v : v;
    endfunction

    function automatic out_t rotate_point(in_t p);
        longint x, y, z, s, c, zs, nx, ny, nz;
        out_t   o;
        x = longint'(p.point_x) * 256;
        y = longint'(p.point_y) * 256;
        z = longint'(p.point_z) * 256;
        s = sine_at(ang_x);
        c = sine_at(ANGLE_BITS'(ang_x + QUARTER));
        zs = round_sat(z * alt_scale, 8);
        ny = round_sat(y * c - zs * s, TRIG_FRAC_BITS);
        nz = round_sat(y * s + zs * c, TRIG_FRAC_BITS);
        y = ny;
        s = sine_at(ang_y);
        c = sine_at(ANGLE_BITS'(ang_y + QUARTER));
        zs = round_sat(nz * alt_scale, 8);
        nx = round_sat(x * c + zs * s, TRIG_FRAC_BITS);
        nz = round_sat(zs * c - x * s, TRIG_FRAC_BITS);
        x = nx;
        s = sine_at(ang_z);
        c = sine_at(ANGLE_BITS'(ang_z + QUARTER));
        o.rotated_x = VAL_W'(round_sat(x * c - y * s, TRIG_FRAC_BITS));
        o.rotated_y = VAL_W'(round_sat(x * s + y * c, TRIG_FRAC_BITS));
        o.rotated_z = VAL_W'(round_sat(nz * alt_scale, 8));
        o.rotated_color = p.point_color;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Request side: one request per cycle unless a gap burst is running.
    always @(negedge clk)
    begin
        logic next_start;
        in_t  next_req;
        next_start = start;
        next_req = request;
        if (!(start && busy))
        begin
            next_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_points.size() > 0)
            begin
                next_req = pending_points.pop_front();
                next_start = 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 11);
            end
        end
        start <= next_start;
        request <= next_req;
    end

    // Register writes, accepted requests and results all resolve at the rising edge.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && wr_en)
        begin
            case (wr_index)
                REG_ANGLE_X: ang_x = wr_data[ANGLE_BITS-1:0];
                REG_ANGLE_Y: ang_y = wr_data[ANGLE_BITS-1:0];
                REG_ANGLE_Z: ang_z = wr_data[ANGLE_BITS-1:0];
                REG_HEIGHT_SCALE: alt_scale = longint'($signed(wr_data));
                default: ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            rotated_expected.push_back(rotate_point(request));
            points_sent++;
        end
        if (rst_n && done)
        begin
            results_seen++;
            if (rotated_expected.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = rotated_expected.pop_front();
                if (result.rotated_x !== want.rotated_x)
                    report_mismatch("rotated_x", result.rotated_x, want.rotated_x);
                if (result.rotated_y !== want.rotated_y)
                    report_mismatch("rotated_y", result.rotated_y, want.rotated_y);
                if (result.rotated_z !== want.rotated_z)
                    report_mismatch("rotated_z", result.rotated_z, want.rotated_z);
                if (result.rotated_color !== want.rotated_color)
                    report_mismatch("rotated_color", result.rotated_color,
                                    want.rotated_color);
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [23:0] col);
        in_t p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        p.point_color = col;
        pending_points.push_back(p);
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && !start);
        wait (rotated_expected.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        wr_index <= idx;
        wr_data <= val;
        wr_en <= 1'b1;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic run_setting(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] hs, int count);
        write_reg(REG_ANGLE_X, ax);
        write_reg(REG_ANGLE_Y, ay);
        write_reg(REG_ANGLE_Z, az);
        write_reg(REG_HEIGHT_SCALE, hs);
        settings_used++;
        repeat (count)
            queue_point(pick_coord(), pick_coord(), pick_coord(), 24'($urandom));
        drain();
    endtask

    // Quarter-wave sine, Q28 Taylor series rounded into the trig fraction width.
    initial
    begin
        longint ang, sq, t, acc;
        for (int i = 0; i <= QUARTER; i++)
        begin
            ang = (longint'(i) * 64'sd421657428 + QUARTER / 2) / QUARTER;
            sq = (ang * ang) >>> 28;
            t = ang;
            acc = ang;
            for (int k = 1; k <= 8; k++)
            begin
                t = ((t * sq) >>> 28) / ((2 * k) * (2 * k + 1));
                acc = (k % 2 == 1) ? acc - t : acc + t;
            end
            acc = (acc < 0) ? 0 : acc;
            acc = (acc > (64'sd1 <<< 28)) ? (64'sd1 <<< 28) : acc;
            sine_quarter[i] = (acc + (64'sd1 <<< (27 - TRIG_FRAC_BITS)))
                              >>> (28 - TRIG_FRAC_BITS);
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed points under reset settings: extremes, zero, all colour bits.
        queue_point(16'h0000, 16'h0000, 16'h0000, 24'h000000);
        queue_point(16'h7fff, 16'h7fff, 16'h7fff, 24'hffffff);
        queue_point(16'h8000, 16'h8000, 16'h8000, 24'h000000);
        queue_point(16'h7fff, 16'h8000, 16'h0001, 24'h123456);
        queue_point(16'hffff, 16'h0001, 16'hffff, 24'hedcba9);
        queue_point(16'h5555, 16'haaaa, 16'h5555, 24'haaaaaa);
        queue_point(16'haaaa, 16'h5555, 16'haaaa, 24'h555555);
        drain();
        settings_used++;

        // Extremes of every register, quarter-turn angles, then random settings.
        run_setting(16'h0fff, 16'h0fff, 16'h0fff, 16'h7fff, 150);
        run_setting(16'h0400, 16'h0800, 16'h0c00, 16'h8000, 150);
        run_setting(16'hffff, 16'hf000, 16'h0001, 16'h0000, 150);
        run_setting(16'h0200, 16'h0600, 16'h0a00, 16'hff00, 150);
        for (int n = 0; n < 7; n++)
            run_setting(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024)),
                        150);
        calm = 1'b1;
        run_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'h0100, 150);

        $display("%0d points accepted, %0d results checked, %0d register settings",
                 points_sent, results_seen, settings_used);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout at %0t", $realtime);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
